// File: sv/adrp_add_pattern_scanner_unit_assert.svh
// Assertion macros used by the checker file of the pattern scanner.
`ifndef ADRP_ADD_PATTERN_SCANNER_UNIT_ASSERT_SVH
`define ADRP_ADD_PATTERN_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ADRP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adrp scanner check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ADRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adrp scanner check failed");

`endif

// File: sv/adrp_pkg.sv
// ----------------------------------------------------------------------------
// adrp_pkg
// Types and fixed constants shared by the ADRP/ADD pattern scanner modules.
// ----------------------------------------------------------------------------
package adrp_pkg;

   // Instruction words of the fixed sequence that marks a site.
   localparam logic [31:0] OP_LDRH = 32'h7940_0020;  // ldrh w0, [x1]
   localparam logic [31:0] OP_AND  = 32'h1213_0400;  // and  w0, w0, #0x6000
   localparam logic [31:0] OP_CMP  = 32'h7140_181f;  // cmp  w0, #0x6, lsl #12

   localparam logic [24:0] SCAN_BYTES_RESET = 25'h080_0000;

   typedef enum logic [0:0] {
      CSR_IMAGE_BASE = 1'b0,
      CSR_SCAN_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_NOT_FOUND = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_CONFLICT  = 2'd2,
      STATUS_NO_BASE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] image_base;
      logic [24:0] scan_bytes;
   } cfg_type;

   // One classified word as handed from the front to the back.
   typedef struct packed {
      logic        hit;        // sequence matched at a qualifying anchor
      logic        last;       // final word of the scan
      logic        no_base;    // image base was zero for this word
      logic [31:0] adrp_word;
      logic [31:0] add_word;
      logic [19:0] pc_page;    // 4 KiB page of the adrp instruction
   } entry_type;

endpackage

// File: sv/adrp_if.sv
// ----------------------------------------------------------------------------
// adrp_req_if / adrp_rsp_if
// Valid/ready channels carrying instruction words in and scan results out.
// ----------------------------------------------------------------------------
interface adrp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        last;

   modport source (output valid, output word, output last, input ready);
   modport sink (input valid, input word, input last, output ready);
endinterface

interface adrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] shadow_address;
   logic [1:0]  status;

   modport source (output valid, output shadow_address, output status, input ready);
   modport sink (input valid, input shadow_address, input status, output ready);
endinterface

// File: sv/adrp_add_pattern_scanner_unit.sv
// Results: the entry of the request marked last passes through the queue and then loads
// the output register, once no earlier result is still waiting at the output.
// Throughput: one request per cycle; the front stalls only while a finished
// result waits at the output and the two-entry queue behind it has filled.
// Reset: synchronous, active high; clears the word index, the found address,
// the conflict flag, the queue and the output valid, and restores the registers.
// ----------------------------------------------------------------------------
// adrp_add_pattern_scanner_unit
// Scans an AArch64 instruction stream for the ldrh/and/cmp site and reports
// the address built by the adrp/add pair in front of it.
// ----------------------------------------------------------------------------
module adrp_add_pattern_scanner_unit import adrp_pkg::*; #(
   parameter int INDEX_BITS = 23
) (
   input  logic        clock,
   input  logic        reset,
   adrp_req_if.sink    req,
   adrp_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Configuration registers. They are read live: a write takes effect from
   // the next request on, and each request carries what it saw into the queue.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_BASE: cfg_in.image_base = csr_wdata;
            CSR_SCAN_BYTES: cfg_in.scan_bytes = csr_wdata[24:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_base <= 32'd0;
         cfg_ff.scan_bytes <= SCAN_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front keeps the four-word window and the word index. For every
   // request it decides whether the current word closes the ldrh/and/cmp
   // sequence at an anchor inside the region, and computes the page of the
   // adrp instruction from the base and the index.
   logic      q_push, q_full, q_pop, q_empty;
   entry_type q_data, q_head;

   adrp_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_data)
   );

   // The queue lets the front keep taking requests while the back holds a
   // result that has not been taken yet.
   adrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // The back decodes each matched site into a candidate address, keeps the
   // first nonzero one, flags a later disagreement, and on the last word of
   // a scan loads the output register and starts over.
   adrp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

// File: sv/adrp_front.sv
// ----------------------------------------------------------------------------
// adrp_front
// Accepts words, keeps the word window and index, and classifies each word.
// ----------------------------------------------------------------------------
module adrp_front import adrp_pkg::*; #(
   parameter int INDEX_BITS = 23
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   adrp_req_if.sink  req,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_data
);

   localparam int OFF_BITS = INDEX_BITS + 2;

   logic [INDEX_BITS-1:0] k_ff, k_in;
   logic [31:0]           win_ff [4];
   logic [31:0]           win_in [4];
   logic                  accept;
   logic                  in_scan;
   logic [OFF_BITS-1:0]   anchor_off, pc_off;
   logic [63:0]           anchor_ext, pc_ext, scan_ext;
   logic [31:0]           pc;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   // Anchor sits two words back; the adrp sits four words back.
   assign anchor_off = {k_ff - INDEX_BITS'(2), 2'b00};
   assign pc_off     = {k_ff - INDEX_BITS'(4), 2'b00};
   assign anchor_ext = 64'(anchor_off);
   assign pc_ext     = 64'(pc_off);
   assign scan_ext   = 64'(cfg.scan_bytes);
   assign pc         = cfg.image_base + pc_ext[31:0];

   assign in_scan = (k_ff != '1) && (k_ff >= INDEX_BITS'(4)) && (anchor_ext < scan_ext);

   always_comb begin
      q_push            = accept;
      q_data.hit        = in_scan && (win_ff[1] == OP_LDRH) && (win_ff[0] == OP_AND)
                          && (req.word == OP_CMP);
      q_data.last       = req.last;
      q_data.no_base    = (cfg.image_base == 32'd0);
      q_data.adrp_word  = win_ff[3];
      q_data.add_word   = win_ff[2];
      q_data.pc_page    = pc[31:12];
   end

   always_comb begin
      k_in      = k_ff;
      win_in[3] = win_ff[3];
      win_in[2] = win_ff[2];
      win_in[1] = win_ff[1];
      win_in[0] = win_ff[0];
      if (accept) begin
         win_in[3] = win_ff[2];
         win_in[2] = win_ff[1];
         win_in[1] = win_ff[0];
         win_in[0] = req.word;
         if (req.last) begin
            k_in = '0;
         end else if (k_ff != '1) begin
            k_in = k_ff + INDEX_BITS'(1);
         end
      end
   end

   // The window needs no clearing: the index gates every use of it.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

endmodule

// File: sv/adrp_queue.sv
// ----------------------------------------------------------------------------
// adrp_queue
// Two-entry queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module adrp_queue import adrp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   entry_type   mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/adrp_back.sv
// ----------------------------------------------------------------------------
// adrp_back
// Decodes candidate addresses, tracks the found address and forms results.
// ----------------------------------------------------------------------------
module adrp_back import adrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       q_empty,
   output logic       q_pop,
   adrp_rsp_if.source rsp
);

   logic [31:0] found_ff, found_in;
   logic        conflict_ff, conflict_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [19:0] page_off;
   logic [31:0] cand;
   logic        out_free;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign q_pop    = !q_empty && (!head.last || out_free);

   // Page plus page offset; imm12 fills the low bits with no carry out.
   assign page_off = {head.adrp_word[22:5], head.adrp_word[30:29]};
   assign cand     = {head.pc_page + page_off, head.add_word[21:10]};

   always_comb begin
      found_in      = found_ff;
      conflict_in   = conflict_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (q_pop) begin
         if (head.hit) begin
            if (found_ff == 32'd0) begin
               found_in = cand;
            end else if (found_ff != cand) begin
               conflict_in = 1'b1;
            end
         end
         if (head.last) begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = 32'd0;
            priority if (head.no_base) begin
               rsp_status_in = STATUS_NO_BASE;
            end else if (found_in != 32'd0 && conflict_in) begin
               rsp_status_in = STATUS_CONFLICT;
            end else if (found_in != 32'd0) begin
               rsp_status_in = STATUS_FOUND;
               rsp_addr_in   = found_in;
            end else begin
               rsp_status_in = STATUS_NOT_FOUND;
            end
            found_in    = 32'd0;
            conflict_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         found_ff     <= 32'd0;
         conflict_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff     <= found_in;
         conflict_ff  <= conflict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.shadow_address = rsp_addr_ff;
   assign rsp.status         = rsp_status_ff;

endmodule

// File: sv/adrp_checker.sv
// ----------------------------------------------------------------------------
// adrp_checker
// Port-level checks of the pattern scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "adrp_add_pattern_scanner_unit_assert.svh"

module adrp_checker import adrp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_shadow_address,
   input logic [1:0]  rsp_status
);

   logic        rsp_stall;
   logic        rsp_found;
   logic        rsp_other;
   logic [33:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_found   = rsp_valid && (rsp_status == STATUS_FOUND);
   assign rsp_other   = rsp_valid && (rsp_status != STATUS_FOUND);
   assign rsp_payload = {rsp_shadow_address, rsp_status};

   `ADRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))
   `ADRP_ASSERT_SAME(a_addr_zero, clock, reset, rsp_other, rsp_shadow_address == 32'd0)
   `ADRP_ASSERT_SAME(a_found_nonzero, clock, reset, rsp_found, rsp_shadow_address != 32'd0)
   `ADRP_ASSERT_SAME(a_stall_cause, clock, reset, !req_ready, rsp_valid)

endmodule

bind adrp_add_pattern_scanner_unit adrp_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_shadow_address (rsp.shadow_address),
   .rsp_status         (rsp.status)
);
